/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on the rising edge with an
// active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle or overlapping-implication property
`define SFPU_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// antecedent, then consequent in the following cycle
`define SFPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/sfpu_pkg.sv */
// ----------------------------------------------------------------------------
// sfpu_pkg
// Shared constants, register codes and saturation helper for the SGD
// factor pair update core.
// ----------------------------------------------------------------------------
package sfpu_pkg;

	localparam int LATENT_LEN  = 2;
	localparam int SQRT_STAGES = 32;
	localparam int DIV_STAGES  = 33;
	// n, n^2, n^3, sqrt, decay mult, denom add, divide, clip
	localparam int STEP_LAT    = 3 + SQRT_STAGES + 2 + DIV_STAGES + 1;
	localparam int LANE_DLY    = STEP_LAT - 4;
	localparam int OUT_LAT     = STEP_LAT + 2;

	localparam logic [31:0] BASE_GAIN_RST  = 32'd16777;
	localparam logic [31:0] GAIN_DECAY_RST = 32'd15099494;
	localparam logic [31:0] REG_WEIGHT_RST = 32'd16777;

	typedef enum logic [1:0] {
		REG_BASE_GAIN  = 2'd0,
		REG_GAIN_DECAY = 2'd1,
		REG_REG_WEIGHT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] val;
		logic               sat;
	} clip_t;

	localparam logic signed [63:0] S32_MAX_W = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] S32_MIN_W = 64'shFFFF_FFFF_8000_0000;

	function automatic clip_t clip32(input logic signed [63:0] x);
		clip_t r;
		if (x > S32_MAX_W) begin
			r.val = 32'sh7FFF_FFFF;
			r.sat = 1'b1;
		end else if (x < S32_MIN_W) begin
			r.val = 32'sh8000_0000;
			r.sat = 1'b1;
		end else begin
			r.val = x[31:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

endpackage

/* rtl/sfpu_step.sv */
// ----------------------------------------------------------------------------
// sfpu_step
// Step size pipeline: n^1.5 by a digit-per-stage square root, decay
// denominator, then a bit-per-stage divider and clip to 32 bits.
// ----------------------------------------------------------------------------
module sfpu_step (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] update_count,
	input  logic [31:0] base_gain,
	input  logic [31:0] gain_decay,
	output logic [31:0] step,
	output logic        step_sat
);
	import sfpu_pkg::*;

	localparam int DW = 58 + DIV_STAGES;

	logic [16:0] n_s1;
	logic [16:0] n_s2;
	logic [33:0] n2_s2;
	logic [48:0] n3_s3;
	logic [63:0] rad;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1  <= {1'b0, update_count} + 17'd1;
			n_s2  <= n_s1;
			n2_s2 <= {17'd0, n_s1} * {17'd0, n_s1};
			n3_s3 <= {15'd0, n2_s2} * {32'd0, n_s2};
		end
	end

	assign rad = {1'b0, n3_s3, 14'd0};

	logic [63:0] sq_v_s    [SQRT_STAGES];
	logic [33:0] sq_rem_s  [SQRT_STAGES];
	logic [31:0] sq_root_s [SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sq
		logic [63:0] v_in;
		logic [33:0] rem_in;
		logic [31:0] root_in;
		logic [35:0] r;
		logic [35:0] t;
		if (k == 0) begin : g_first
			assign v_in    = rad;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign v_in    = sq_v_s[k-1];
			assign rem_in  = sq_rem_s[k-1];
			assign root_in = sq_root_s[k-1];
		end
		assign r = {rem_in, v_in[63-2*k -: 2]};
		assign t = {2'b00, root_in, 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				sq_v_s[k] <= v_in;
				if (r >= t) begin
					sq_rem_s[k]  <= 34'(r - t);
					sq_root_s[k] <= {root_in[30:0], 1'b1};
				end else begin
					sq_rem_s[k]  <= r[33:0];
					sq_root_s[k] <= {root_in[30:0], 1'b0};
				end
			end
		end
	end

	logic [63:0] pm_s;
	logic [57:0] den_s;
	logic [33:0] lr3;
	logic [56:0] num;

	always_ff @(posedge clk) begin
		if (en) begin
			pm_s  <= {32'd0, gain_decay} * {32'd0, sq_root_s[SQRT_STAGES-1]};
			den_s <= {1'b0, pm_s[63:7]} + 58'h100_0000;
		end
	end

	assign lr3 = {2'b00, base_gain} + {1'b0, base_gain, 1'b0};
	assign num = {lr3, 23'd0};

	logic [56:0] dv_rem_s [DIV_STAGES];
	logic [32:0] dv_q_s   [DIV_STAGES];
	logic [57:0] dv_den_s [DIV_STAGES];

	for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
		localparam int J = DIV_STAGES - 1 - s;
		logic [56:0]   rem_in;
		logic [32:0]   q_in;
		logic [57:0]   den_in;
		logic [DW-1:0] den_sh;
		logic          ge;
		if (s == 0) begin : g_first
			assign rem_in = num;
			assign q_in   = '0;
			assign den_in = den_s;
		end else begin : g_next
			assign rem_in = dv_rem_s[s-1];
			assign q_in   = dv_q_s[s-1];
			assign den_in = dv_den_s[s-1];
		end
		assign den_sh = {{DIV_STAGES{1'b0}}, den_in} << J;
		assign ge     = {{(DW-57){1'b0}}, rem_in} >= den_sh;
		always_ff @(posedge clk) begin
			if (en) begin
				dv_den_s[s] <= den_in;
				dv_q_s[s]   <= {q_in[31:0], ge};
				dv_rem_s[s] <= ge ? (rem_in - den_sh[56:0]) : rem_in;
			end
		end
	end

	logic [32:0] q_fin;
	assign q_fin = dv_q_s[DIV_STAGES-1];

	always_ff @(posedge clk) begin
		if (en) begin
			step     <= q_fin[32] ? 32'hFFFF_FFFF : q_fin[31:0];
			step_sat <= q_fin[32];
		end
	end

endmodule

/* rtl/sfpu_lane.sv */
// ----------------------------------------------------------------------------
// sfpu_lane
// One latent element pair: product for the dot sum, gradients, delay to
// meet the step size, then the scaled update with saturation.
// ----------------------------------------------------------------------------
module sfpu_lane (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] item,
	input  logic signed [31:0] user,
	input  logic signed [31:0] err,
	input  logic               err_sat,
	input  logic        [31:0] reg_weight,
	input  logic        [31:0] step,
	input  logic               step_sat,
	output logic signed [63:0] prod,
	output logic signed [31:0] new_item,
	output logic signed [31:0] new_user,
	output logic               sat
);
	import sfpu_pkg::*;

	typedef struct packed {
		logic signed [31:0] item;
		logic signed [31:0] user;
		logic signed [31:0] gi;
		logic signed [31:0] gu;
		logic               sat;
	} dly_t;

	logic signed [31:0] item_s1, user_s1, item_s2, user_s2, item_s3, user_s3;
	logic signed [63:0] prod_s1;
	logic signed [63:0] peu_s3, pei_s3;
	logic signed [64:0] pri_s3, pru_s3;
	logic               esat_s3;
	logic signed [63:0] gi_w, gu_w;
	clip_t              ci, cu;
	dly_t               g_s4;
	dly_t               dly_s [LANE_DLY];
	dly_t               tail;
	logic signed [64:0] mi_s5, mu_s5;
	logic signed [31:0] item_s5, user_s5;
	logic               sat_s5;
	logic signed [63:0] ni_w, nu_w;
	clip_t              cni, cnu;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= item * user;
			item_s1 <= item;
			user_s1 <= user;
			item_s2 <= item_s1;
			user_s2 <= user_s1;
			peu_s3  <= err * user_s2;
			pei_s3  <= err * item_s2;
			pri_s3  <= $signed({1'b0, reg_weight}) * item_s2;
			pru_s3  <= $signed({1'b0, reg_weight}) * user_s2;
			esat_s3 <= err_sat;
			item_s3 <= item_s2;
			user_s3 <= user_s2;
		end
	end

	assign prod = prod_s1;

	assign gi_w = $signed(peu_s3[63:24]) - $signed(pri_s3[64:24]);
	assign gu_w = $signed(pei_s3[63:24]) - $signed(pru_s3[64:24]);
	assign ci   = clip32(gi_w);
	assign cu   = clip32(gu_w);

	always_ff @(posedge clk) begin
		if (en) begin
			g_s4.item <= item_s3;
			g_s4.user <= user_s3;
			g_s4.gi   <= ci.val;
			g_s4.gu   <= cu.val;
			g_s4.sat  <= esat_s3 | ci.sat | cu.sat;
			dly_s[0]  <= g_s4;
			for (int k = 1; k < LANE_DLY; k++) begin
				dly_s[k] <= dly_s[k-1];
			end
		end
	end

	assign tail = dly_s[LANE_DLY-1];

	always_ff @(posedge clk) begin
		if (en) begin
			mi_s5   <= $signed({1'b0, step}) * tail.gi;
			mu_s5   <= $signed({1'b0, step}) * tail.gu;
			item_s5 <= tail.item;
			user_s5 <= tail.user;
			sat_s5  <= tail.sat | step_sat;
		end
	end

	assign ni_w = item_s5 + $signed(mi_s5[64:24]);
	assign nu_w = user_s5 + $signed(mu_s5[64:24]);
	assign cni  = clip32(ni_w);
	assign cnu  = clip32(nu_w);

	always_ff @(posedge clk) begin
		if (en) begin
			new_item <= cni.val;
			new_user <= cnu.val;
			sat      <= sat_s5 | cni.sat | cnu.sat;
		end
	end

endmodule

/* rtl/sgd_factor_pair_update_core.sv */
// ----------------------------------------------------------------------------
// sgd_factor_pair_update_core
// One SGD step of two-factor matrix factorization per rating request.
// ----------------------------------------------------------------------------
// Fully pipelined: unless the output stalls, a new request is taken every cycle
// and its result is shown once its valid bit reaches the top of vld_q.
// The pipeline depth is set by the step size path: a 32-stage square root for
// (count+1)^1.5 followed by a 33-stage divider. The whole pipeline stalls only
// while a result waits at the output with out_ready low. Configuration
// registers are read live and must be written while idle.
module sgd_factor_pair_update_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] item_lat0,
	input  logic signed [31:0] item_lat1,
	input  logic signed [31:0] user_lat0,
	input  logic signed [31:0] user_lat1,
	input  logic        [7:0]  rating,
	input  logic        [15:0] update_count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] new_item_lat0,
	output logic signed [31:0] new_item_lat1,
	output logic signed [31:0] new_user_lat0,
	output logic signed [31:0] new_user_lat1,
	output logic               saturated,
	input  logic               cfg_we,
	input  logic        [1:0]  cfg_index,
	input  logic        [31:0] cfg_wdata
);
	import sfpu_pkg::*;

	logic [31:0] base_gain_q, gain_decay_q, reg_weight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_gain_q  <= BASE_GAIN_RST;
			gain_decay_q <= GAIN_DECAY_RST;
			reg_weight_q <= REG_WEIGHT_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_BASE_GAIN:  base_gain_q  <= cfg_wdata;
				REG_GAIN_DECAY: gain_decay_q <= cfg_wdata;
				REG_REG_WEIGHT: reg_weight_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic               en;
	logic [OUT_LAT-1:0] vld_q;

	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[OUT_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[OUT_LAT-2:0], in_valid};
		end
	end

	logic [31:0] step;
	logic        step_sat;

	sfpu_step u_step (
		.clk          (clk),
		.en           (en),
		.update_count (update_count),
		.base_gain    (base_gain_q),
		.gain_decay   (gain_decay_q),
		.step         (step),
		.step_sat     (step_sat)
	);

	logic signed [31:0] item_w     [LATENT_LEN];
	logic signed [31:0] user_w     [LATENT_LEN];
	logic signed [63:0] prod_w     [LATENT_LEN];
	logic signed [31:0] new_item_w [LATENT_LEN];
	logic signed [31:0] new_user_w [LATENT_LEN];
	logic [LATENT_LEN-1:0] sat_w;

	assign item_w[0] = item_lat0;
	assign item_w[1] = item_lat1;
	assign user_w[0] = user_lat0;
	assign user_w[1] = user_lat1;

	// merge: dot product and error
	logic        [7:0]  rating_s1;
	logic signed [41:0] dot;
	logic signed [63:0] err_w;
	clip_t              err_c;
	logic signed [31:0] err_s2;
	logic               esat_s2;

	always_comb begin
		dot = '0;
		for (int l = 0; l < LATENT_LEN; l++) begin
			dot = dot + $signed(prod_w[l][63:24]);
		end
	end

	assign err_w = $signed({32'd0, rating_s1, 24'd0}) - dot;
	assign err_c = clip32(err_w);

	always_ff @(posedge clk) begin
		if (en) begin
			rating_s1 <= rating;
			err_s2    <= err_c.val;
			esat_s2   <= err_c.sat;
		end
	end

	for (genvar l = 0; l < LATENT_LEN; l++) begin : g_lane
		sfpu_lane u_lane (
			.clk       (clk),
			.en        (en),
			.item      (item_w[l]),
			.user      (user_w[l]),
			.err       (err_s2),
			.err_sat   (esat_s2),
			.reg_weight(reg_weight_q),
			.step      (step),
			.step_sat  (step_sat),
			.prod      (prod_w[l]),
			.new_item  (new_item_w[l]),
			.new_user  (new_user_w[l]),
			.sat       (sat_w[l])
		);
	end

	assign new_item_lat0 = new_item_w[0];
	assign new_item_lat1 = new_item_w[1];
	assign new_user_lat0 = new_user_w[0];
	assign new_user_lat1 = new_user_w[1];
	assign saturated     = |sat_w;

endmodule

/* rtl/sfpu_checker.sv */
// ----------------------------------------------------------------------------
// sfpu_checker
// Port-level checks on the request and result channels, bound to the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfpu_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] new_item_lat0,
	input logic signed [31:0] new_item_lat1,
	input logic signed [31:0] new_user_lat0,
	input logic signed [31:0] new_user_lat1,
	input logic               saturated
);

	logic         stalled;
	logic [128:0] res_bus;
	assign stalled = out_valid && !out_ready && (in_valid || !in_valid);
	assign res_bus = {new_item_lat0, new_item_lat1, new_user_lat0, new_user_lat1, saturated};

	`SFPU_ASSERT_NEXT(a_out_hold, clk, arst_n, stalled, out_valid)
	`SFPU_ASSERT_NEXT(a_data_hold, clk, arst_n, stalled, $stable(res_bus))
	`SFPU_ASSERT(a_ready_when_empty, clk, arst_n, !out_valid |-> in_ready)
	`SFPU_ASSERT(a_stall_blocks_in, clk, arst_n, stalled |-> !in_ready)

endmodule

bind sgd_factor_pair_update_core sfpu_checker u_sfpu_checker (.*);
